/* hw/rtl/tblc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package tblc_pkg;

	localparam int COUNT_W   = 12;
	localparam int READING_W = 16;
	localparam int CH_W      = 2;

	localparam logic [1:0] CH_WATER_TANK = 2'd0;
	localparam logic [1:0] CH_BATTERY    = 2'd1;
	localparam logic [1:0] CH_FUEL       = 2'd2;
	localparam logic [1:0] CH_UNUSED     = 2'd3;

	localparam logic [1:0] MODE_240_33 = 2'd1;
	localparam logic [1:0] MODE_0_190  = 2'd2;

	localparam logic [2:0] REG_FULL_SCALE = 3'd0;
	localparam logic [2:0] REG_BAT_TRIM   = 3'd1;
	localparam logic [2:0] REG_WATER_TRIM = 3'd2;
	localparam logic [2:0] REG_FUEL_TRIM  = 3'd3;
	localparam logic [2:0] REG_WATER_MODE = 3'd4;
	localparam logic [2:0] REG_FUEL_MODE  = 3'd5;

	localparam logic [11:0] FULL_SCALE_DIV = 12'd4095;
	localparam logic [11:0] BAT_MUL        = 12'd1200;
	localparam logic [11:0] OHM_MUL        = 12'd190;
	localparam logic [11:0] OHM_DIV        = 12'd950;
	localparam logic [11:0] PCT_MUL        = 12'd100;
	localparam logic [11:0] SPAN_240_33    = 12'd207;
	localparam logic [11:0] SPAN_0_190     = 12'd190;
	localparam logic [7:0]  BAT_TRIM_DEF   = 8'd120;
	localparam logic [7:0]  TANK_TRIM_DEF  = 8'd100;

endpackage
`default_nettype wire

/* hw/rtl/tblc_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface tblc_sample_if;
	import tblc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CH_W-1:0]      channel;
	logic [COUNT_W-1:0]   raw_count;
	modport source (output valid, channel, raw_count, input ready);
	modport sink   (input valid, channel, raw_count, output ready);
endinterface

interface tblc_result_if;
	import tblc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CH_W-1:0]      channel_out;
	logic [READING_W-1:0] reading;
	modport source (output valid, channel_out, reading, input ready);
	modport sink   (input valid, channel_out, reading, output ready);
endinterface
`default_nettype wire

/* hw/rtl/tank_and_battery_level_conditioner_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// one item at a time through a bit-serial shift-add multiplier and a restoring divider,
// two to four passes per item: two for the battery, three for a tank, four when a tank
// percent meter mode needs its division; the next item is taken only once the result
// has loaded into the output register and the core is back in idle;
// a finished item waits while the output register is full. reset (arst_n low, async): defaults, unseeded
module tank_and_battery_level_conditioner_core #(
	parameter int TANK_SMOOTH_SHIFT    = 11,
	parameter int BATTERY_SMOOTH_SHIFT = 7
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	tblc_sample_if.sink       sample,
	tblc_result_if.source     result,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [4:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic      [31:0]  prdata,
	output logic              pready
);
	import tblc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL, ST_DIV, ST_SMOOTH, ST_PCT, ST_FIN
	} state_t;

	// configuration registers
	logic [11:0] full_scale_q;
	logic [7:0]  bat_trim_q, water_trim_q, fuel_trim_q;
	logic [1:0]  water_mode_q, fuel_mode_q;
	logic [2:0]  reg_idx;

	assign reg_idx = paddr[4:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_scale_q <= 12'd2048;
			bat_trim_q   <= BAT_TRIM_DEF;
			water_trim_q <= TANK_TRIM_DEF;
			fuel_trim_q  <= TANK_TRIM_DEF;
			water_mode_q <= 2'd0;
			fuel_mode_q  <= 2'd0;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_FULL_SCALE: full_scale_q <= pwdata[11:0];
				REG_BAT_TRIM:   bat_trim_q   <= pwdata[7:0];
				REG_WATER_TRIM: water_trim_q <= pwdata[7:0];
				REG_FUEL_TRIM:  fuel_trim_q  <= pwdata[7:0];
				REG_WATER_MODE: water_mode_q <= pwdata[1:0];
				REG_FUEL_MODE:  fuel_mode_q  <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_FULL_SCALE: prdata = {20'd0, full_scale_q};
			REG_BAT_TRIM:   prdata = {24'd0, bat_trim_q};
			REG_WATER_TRIM: prdata = {24'd0, water_trim_q};
			REG_FUEL_TRIM:  prdata = {24'd0, fuel_trim_q};
			REG_WATER_MODE: prdata = {30'd0, water_mode_q};
			REG_FUEL_MODE:  prdata = {30'd0, fuel_mode_q};
			default:        prdata = 32'd0;
		endcase
	end

	// datapath state
	state_t      state_q;
	logic [1:0]  step_q;         // which mul/div pass is running
	logic [4:0]  cnt_q;          // bit counter inside a pass
	logic [1:0]  ch_q;
	logic [23:0] prod_q, mcand_q, num_q;
	logic [11:0] mplier_q, div_q, rem_q;
	logic [15:0] sm_q, res_q;
	logic [27:0] acc_q [3];
	logic [2:0]  seeded_q;
	logic        out_valid_q;
	logic [1:0]  out_ch_q;
	logic [15:0] out_reading_q;

	assign sample.ready        = (state_q == ST_IDLE);
	assign result.valid        = out_valid_q;
	assign result.channel_out  = out_ch_q;
	assign result.reading      = out_reading_q;

	// one multiplier bit per cycle
	logic [23:0] prod_nx;
	assign prod_nx = prod_q + (mplier_q[0] ? mcand_q : 24'd0);

	// one quotient bit per cycle, quotient shifts into num
	logic [12:0] trial, trial_sub;
	logic        trial_ge;
	logic [23:0] num_nx;
	logic [11:0] rem_nx;
	assign trial     = {rem_q, num_q[23]};
	assign trial_ge  = trial >= {1'b0, div_q};
	assign trial_sub = trial - {1'b0, div_q};
	assign rem_nx    = trial_ge ? trial_sub[11:0] : trial[11:0];
	assign num_nx    = {num_q[22:0], trial_ge};

	logic [15:0] q_sat;
	assign q_sat = (|num_nx[23:16]) ? 16'hFFFF : num_nx[15:0];

	// calibration divisors, zero trim selects the default
	logic [11:0] bat_cal, tank_cal;
	logic [7:0]  tank_trim;
	assign tank_trim = (ch_q == CH_FUEL) ? fuel_trim_q : water_trim_q;
	assign bat_cal   = {4'd0, (bat_trim_q == 8'd0) ? BAT_TRIM_DEF : bat_trim_q};
	assign tank_cal  = {4'd0, (tank_trim == 8'd0) ? TANK_TRIM_DEF : tank_trim};

	// exponential average
	logic        is_bat;
	logic [27:0] acc_cur, acc_shr, acc_seed, acc_new;
	logic [15:0] sm_new;
	logic [1:0]  mode;
	assign is_bat   = (ch_q == CH_BATTERY);
	assign acc_cur  = acc_q[ch_q];
	assign acc_shr  = is_bat ? (acc_cur >> BATTERY_SMOOTH_SHIFT)
	                         : (acc_cur >> TANK_SMOOTH_SHIFT);
	assign acc_seed = is_bat ? (28'(sm_q) << BATTERY_SMOOTH_SHIFT)
	                         : (28'(sm_q) << TANK_SMOOTH_SHIFT);
	assign acc_new  = seeded_q[ch_q] ? (acc_cur - acc_shr + 28'(sm_q)) : acc_seed;
	assign sm_new   = is_bat ? 16'(acc_new >> BATTERY_SMOOTH_SHIFT)
	                         : 16'(acc_new >> TANK_SMOOTH_SHIFT);
	assign mode     = (ch_q == CH_FUEL) ? fuel_mode_q : water_mode_q;

	logic [15:0] span_240;
	assign span_240 = 16'd240 - sm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= 2'd0;
			cnt_q       <= 5'd0;
			seeded_q    <= 3'b000;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) acc_q[i] <= 28'd0;
		end else begin
			if (result.ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (sample.valid && sample.channel != CH_UNUSED) begin
						ch_q     <= sample.channel;
						mcand_q  <= {12'd0, sample.raw_count};
						mplier_q <= full_scale_q;
						div_q    <= FULL_SCALE_DIV;
						prod_q   <= 24'd0;
						cnt_q    <= 5'd0;
						step_q   <= 2'd0;
						state_q  <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q   <= prod_nx;
					mcand_q  <= {mcand_q[22:0], 1'b0};
					mplier_q <= {1'b0, mplier_q[11:1]};
					cnt_q    <= cnt_q + 5'd1;
					if (cnt_q == 5'd11) begin
						num_q   <= prod_nx;
						rem_q   <= 12'd0;
						cnt_q   <= 5'd0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					num_q <= num_nx;
					rem_q <= rem_nx;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd23) begin
						cnt_q   <= 5'd0;
						prod_q  <= 24'd0;
						mcand_q <= {12'd0, num_nx[11:0]};
						step_q  <= step_q + 2'd1;
						state_q <= ST_MUL;
						case (step_q)
							2'd0: begin
								// millivolts ready
								mplier_q <= is_bat ? BAT_MUL : OHM_MUL;
								div_q    <= is_bat ? bat_cal : OHM_DIV;
							end
							2'd1: begin
								if (is_bat) begin
									sm_q    <= q_sat;
									state_q <= ST_SMOOTH;
								end else begin
									mplier_q <= PCT_MUL;
									div_q    <= tank_cal;
								end
							end
							2'd2: begin
								sm_q    <= q_sat;
								state_q <= ST_SMOOTH;
							end
							default: begin
								res_q   <= num_nx[15:0];
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_SMOOTH: begin
					acc_q[ch_q]    <= acc_new;
					seeded_q[ch_q] <= 1'b1;
					sm_q           <= sm_new;
					res_q          <= sm_new;
					state_q        <= is_bat ? ST_FIN : ST_PCT;
				end
				ST_PCT: begin
					state_q  <= ST_FIN;
					prod_q   <= 24'd0;
					cnt_q    <= 5'd0;
					step_q   <= 2'd3;
					mplier_q <= PCT_MUL;
					if (mode == MODE_240_33) begin
						if (sm_q > 16'd360)      res_q <= 16'd255;
						else if (sm_q >= 16'd240) res_q <= 16'd0;
						else if (sm_q <= 16'd33)  res_q <= 16'd100;
						else begin
							mcand_q <= {12'd0, span_240[11:0]};
							div_q   <= SPAN_240_33;
							state_q <= ST_MUL;
						end
					end else if (mode == MODE_0_190) begin
						if (sm_q > 16'd285)      res_q <= 16'd255;
						else if (sm_q >= 16'd190) res_q <= 16'd100;
						else begin
							mcand_q <= {12'd0, sm_q[11:0]};
							div_q   <= SPAN_0_190;
							state_q <= ST_MUL;
						end
					end else begin
						res_q <= (sm_q > 16'd255) ? 16'd255 : sm_q;
					end
				end
				ST_FIN: begin
					if (!out_valid_q || result.ready) begin
						out_valid_q   <= 1'b1;
						out_ch_q      <= ch_q;
						out_reading_q <= res_q;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire
